// ----- sv/cpf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the mod-11 check-digit function for the CPF validator.
// No dependencies; used by cpf_bcd_cell, cpf_check_stage and the top level.
package cpf_pkg;

  localparam int unsigned IdW       = 37;
  localparam int unsigned NumDigits = 11;
  // 12 BCD digits cover the full 37-bit input range
  localparam int unsigned BcdW      = 48;
  localparam int unsigned SumW      = 10;

  localparam logic [IdW-1:0] CpfMax = 37'd99999999999;

  typedef logic [SumW-1:0] sum_t;

  // data walking down the binary-to-BCD chain
  typedef struct packed {
    logic            valid;
    logic            over;
    logic [BcdW-1:0] bcd;
    logic [IdW-1:0]  bin;
  } cpf_cell_t;

  typedef struct packed {
    logic       is_valid;
    logic [3:0] c1;
    logic [3:0] c2;
    logic       rej;
  } cpf_res_t;

  // remainder mod 11 via reciprocal (186/2048 underestimates 1/11), one fix-up
  function automatic logic [3:0] check_digit(input sum_t x);
    logic [16:0] prod;
    logic [5:0]  q;
    logic [9:0]  r;
    prod = 17'(x) * 17'd186;
    q    = prod[16:11];
    r    = x - (10'(q) * 10'd11);
    if (r >= 10'd11) begin
      r = r - 10'd11;
    end
    if (r < 10'd2) begin
      check_digit = 4'd0;
    end else begin
      check_digit = 4'(10'd11 - r);
    end
  endfunction

endpackage

// ----- sv/cpf_bcd_cell.sv -----
`timescale 1ns / 1ps
// One double-dabble cell: add-3 adjust on every BCD digit, then shift in one binary bit.
// Depends on cpf_pkg.
module cpf_bcd_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  cpf_pkg::cpf_cell_t in_i,
  output cpf_pkg::cpf_cell_t out_o
);
  import cpf_pkg::*;

  logic [BcdW-1:0] bcd_adj;
  logic            valid_q;
  logic            over_q;
  logic [BcdW-1:0] bcd_q;
  logic [IdW-1:0]  bin_q;

  always_comb begin
    for (int k = 0; k < BcdW / 4; k++) begin
      if (in_i.bcd[k*4 +: 4] >= 4'd5) begin
        bcd_adj[k*4 +: 4] = in_i.bcd[k*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[k*4 +: 4] = in_i.bcd[k*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      over_q <= in_i.over;
      bcd_q  <= {bcd_adj[BcdW-2:0], in_i.bin[IdW-1]};
      bin_q  <= {in_i.bin[IdW-2:0], 1'b0};
    end
  end

  assign out_o = '{valid: valid_q, over: over_q, bcd: bcd_q, bin: bin_q};

endmodule

// ----- sv/cpf_check_stage.sv -----
`timescale 1ns / 1ps
// Weighted sums, check digits and repeated-digit test on the 11 decoded digits.
// Two register stages; final compare is combinational. Depends on cpf_pkg.
module cpf_check_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cpf_pkg::cpf_cell_t in_i,
  output logic               valid_o,
  output cpf_pkg::cpf_res_t  res_o
);
  import cpf_pkg::*;

  logic [3:0] dig [NumDigits];   // dig[0] is the most significant digit
  sum_t       s1_d, s2_d;
  logic       rep_d;

  logic       a_valid_q, a_over_q, a_rej_q;
  sum_t       a_s1_q, a_s2_q;
  logic [3:0] a_d10_q, a_d11_q;

  logic       b_valid_q, b_over_q, b_rej_q;
  logic [3:0] b_c1_q;
  sum_t       b_s2_q;
  logic [3:0] b_d10_q, b_d11_q;

  logic [3:0] c2;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      dig[i] = in_i.bcd[(NumDigits-1-i)*4 +: 4];
    end
    s1_d = '0;
    s2_d = '0;
    for (int i = 0; i < 9; i++) begin
      s1_d = s1_d + SumW'(dig[i]) * SumW'(10 - i);
      s2_d = s2_d + SumW'(dig[i]) * SumW'(11 - i);
    end
    // all eleven digits equal (covers zero); top BCD digit only matters above max
    rep_d = 1'b1;
    for (int i = 0; i < NumDigits - 1; i++) begin
      if (dig[i] != dig[NumDigits-1]) begin
        rep_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= in_i.valid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_over_q <= in_i.over;
      a_rej_q  <= rep_d;
      a_s1_q   <= s1_d;
      a_s2_q   <= s2_d;
      a_d10_q  <= dig[NumDigits-2];
      a_d11_q  <= dig[NumDigits-1];

      b_over_q <= a_over_q;
      b_rej_q  <= a_rej_q;
      b_c1_q   <= check_digit(a_s1_q);
      // second sum gets the first check digit with weight 2
      b_s2_q   <= a_s2_q + SumW'({check_digit(a_s1_q), 1'b0});
      b_d10_q  <= a_d10_q;
      b_d11_q  <= a_d11_q;
    end
  end

  assign c2 = check_digit(b_s2_q);

  always_comb begin
    if (b_over_q) begin
      res_o = '{is_valid: 1'b0, c1: 4'd0, c2: 4'd0, rej: 1'b1};
    end else begin
      res_o.is_valid = !b_rej_q && (b_c1_q == b_d10_q) && (c2 == b_d11_q);
      res_o.c1       = b_c1_q;
      res_o.c2       = c2;
      res_o.rej      = b_rej_q;
    end
  end

  assign valid_o = b_valid_q;

endmodule

// ----- sv/cpf_check_digit_validator.sv -----
`timescale 1ns / 1ps
// CPF check-digit validator. Accepts one 37-bit number per cycle while stall_o is low and
// returns one result per item: the two mod-11 check digits computed from the nine
// leading decimal digits, a match flag and a reject flag (repeated digits, zero, or above
// 99999999999). 37 double-dabble cells, one per input bit, turn the binary number into
// BCD, then two stages form the weighted sums and check digits, then the output register.
// Sustained rate is one item per cycle while the skid buffer is empty; a one-entry skid
// buffer behind the output register lets one more item in while a result is stalled.
// Depends on cpf_pkg, cpf_bcd_cell and cpf_check_stage.
module cpf_check_digit_validator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [cpf_pkg::IdW-1:0] id_number_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic                  is_valid_o,
  output logic [3:0]            expected_first_check_o,
  output logic [3:0]            expected_second_check_o,
  output logic                  rejected_pattern_o
);
  import cpf_pkg::*;

  cpf_cell_t chain [IdW+1];
  logic      adv;
  logic      res_valid;
  cpf_res_t  res;

  logic      out_valid_q, out_valid_d;
  cpf_res_t  out_q, out_d;
  logic      skid_valid_q, skid_valid_d;
  cpf_res_t  skid_q, skid_d;

  // whole pipeline moves unless the skid slot is occupied
  assign adv     = !skid_valid_q;
  assign stall_o = skid_valid_q;

  assign chain[0] = '{valid: valid_i, over: (id_number_i > CpfMax), bcd: '0, bin: id_number_i};

  for (genvar g = 0; g < IdW; g++) begin : g_cell
    cpf_bcd_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .in_i  (chain[g]),
      .out_o (chain[g+1])
    );
  end

  cpf_check_stage u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .in_i   (chain[IdW]),
    .valid_o(res_valid),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (!stall_i) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || !stall_i) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end
    end else if (!stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o                 = out_valid_q;
  assign is_valid_o              = out_q.is_valid;
  assign expected_first_check_o  = out_q.c1;
  assign expected_second_check_o = out_q.c2;
  assign rejected_pattern_o      = out_q.rej;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && stall_i))
    else $error("skid filled without a stalled output");

  a_valid_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_valid_o) |-> !rejected_pattern_o)
    else $error("item reported valid and rejected");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (expected_first_check_o <= 4'd9 && expected_second_check_o <= 4'd9))
    else $error("check digit out of range");

endmodule

// ----- tb/cpf_check_digit_validator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for cpf_check_digit_validator: feeds 37-bit taxpayer numbers, predicts
// both mod-11 check digits and the match/reject flags, and checks every result in order.
// Depends on cpf_pkg and the validator RTL.
module cpf_check_digit_validator_tb;
  import cpf_pkg::*;

  localparam int unsigned NumRandom     = 1630;
  localparam int unsigned TailItems     = 150;   // no idling once this few items remain
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldAfter     = 500;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned PrintLimit    = 50;
  localparam longint unsigned RepUnit   = 64'd11111111111;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           valid_i = 1'b0;
  logic           stall_o;
  logic [IdW-1:0] id_number_i = '0;
  logic           valid_o;
  logic           stall_i = 1'b0;
  logic           is_valid_o;
  logic [3:0]     expected_first_check_o;
  logic [3:0]     expected_second_check_o;
  logic           rejected_pattern_o;

  logic [IdW-1:0] ids_to_send[$];
  cpf_res_t       predicted_checks[$];
  int unsigned    mismatches = 0;
  int unsigned    results_seen = 0;
  int unsigned    send_gap = 0;
  int unsigned    recv_gap = 0;
  int unsigned    hold_left = 0;
  bit             hold_done = 1'b0;
  int unsigned    quiet_cycles = 0;

  cpf_check_digit_validator dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .valid_i                 (valid_i),
    .stall_o                 (stall_o),
    .id_number_i             (id_number_i),
    .valid_o                 (valid_o),
    .stall_i                 (stall_i),
    .is_valid_o              (is_valid_o),
    .expected_first_check_o  (expected_first_check_o),
    .expected_second_check_o (expected_second_check_o),
    .rejected_pattern_o      (rejected_pattern_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic cpf_res_t cpf_predict(logic [IdW-1:0] id);
    cpf_res_t        res;
    longint unsigned rest;
    int unsigned     dig[11];
    int unsigned     s1;
    int unsigned     s2;
    int unsigned     c1;
    int unsigned     c2;
    res = '0;
    // out of 11-digit range: reject, digits forced to zero
    if (id > CpfMax) begin
      res.rej = 1'b1;
      return res;
    end
    rest = 64'(id);
    for (int i = 10; i >= 0; i--) begin
      dig[i] = 32'(rest % 64'd10);
      rest   = rest / 64'd10;
    end
    s1 = 0;
    s2 = 0;
    for (int i = 0; i < 9; i++) begin
      s1 += dig[i] * (10 - i);
      s2 += dig[i] * (11 - i);
    end
    c1 = (s1 % 11 < 2) ? 0 : 11 - s1 % 11;
    s2 += 2 * c1;
    c2 = (s2 % 11 < 2) ? 0 : 11 - s2 % 11;
    // zero and eleven equal digits are all multiples of 11111111111 here
    res.rej      = (64'(id) % RepUnit) == 0;
    res.c1       = 4'(c1);
    res.c2       = 4'(c2);
    res.is_valid = !res.rej && c1 == dig[9] && c2 == dig[10];
    return res;
  endfunction

  // nine leading digits plus their correct check digits
  function automatic logic [IdW-1:0] cpf_with_checks(longint unsigned body);
    logic [IdW-1:0] id;
    cpf_res_t       p;
    id = IdW'(body * 64'd100);
    p  = cpf_predict(id);
    return id + IdW'(p.c1) * 10 + IdW'(p.c2);
  endfunction

  task automatic flag_mismatch(string field, logic [3:0] want, logic [3:0] got);
    mismatches++;
    if (mismatches <= PrintLimit) begin
      $display("%0t: result %0d: %s expected %0d, got %0d", $realtime, results_seen, field,
               want, got);
    end
  endtask

  initial begin : stimulus
    logic [IdW-1:0]  id;
    longint unsigned body;
    int unsigned     pick;
    // every repeated-digit pattern, zero included
    for (int k = 0; k < 10; k++) begin
      ids_to_send.push_back(IdW'(RepUnit * k));
    end
    ids_to_send.push_back(CpfMax + 1);
    ids_to_send.push_back('1);
    ids_to_send.push_back(IdW'(64'h10_0000_0000));
    ids_to_send.push_back(IdW'(1));
    ids_to_send.push_back(IdW'(64'd11111111110));
    ids_to_send.push_back(cpf_with_checks(64'd1));
    ids_to_send.push_back(cpf_with_checks(64'd999999999));
    ids_to_send.push_back(cpf_with_checks(64'd123456789));
    ids_to_send.push_back(cpf_with_checks(64'd123456789) + 1);
    ids_to_send.push_back(cpf_with_checks(64'd123456789) + 10);
    for (int n = 0; n < NumRandom; n++) begin
      pick = $urandom_range(0, 99);
      body = 64'($urandom_range(0, 999999999));
      if (pick < 50) begin
        id = cpf_with_checks(body);
      end else if (pick < 65) begin
        id = IdW'(body * 64'd100 + 64'($urandom_range(0, 99)));
      end else if (pick < 80) begin
        id = IdW'(64'($urandom_range(0, 99999)) * 64'd1000000 +
                  64'($urandom_range(0, 999999)));
      end else if (pick < 92) begin
        id = {5'($urandom_range(0, 31)), 32'($urandom)};
      end else if (pick < 96) begin
        id = IdW'(RepUnit * $urandom_range(0, 9) + 64'($urandom_range(0, 2)));
      end else begin
        id = CpfMax - 2 + IdW'($urandom_range(0, 4));
      end
      ids_to_send.push_back(id);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (ids_to_send.size() != 0 || valid_i || predicted_checks.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin : driver
    if (!rst_ni) begin
      valid_i     <= 1'b0;
      id_number_i <= '0;
      send_gap    <= 0;
    end else begin
      if (valid_i && !stall_o) begin
        predicted_checks.push_back(cpf_predict(id_number_i));
      end
      // a stalled item stays put
      if (!valid_i || !stall_o) begin
        if (send_gap != 0) begin
          valid_i  <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (ids_to_send.size() == 0) begin
          valid_i <= 1'b0;
        end else if (ids_to_send.size() > TailItems && $urandom_range(0, 9) == 0) begin
          valid_i  <= 1'b0;
          send_gap <= $urandom_range(0, 16);
        end else begin
          valid_i     <= 1'b1;
          id_number_i <= ids_to_send.pop_front();
        end
      end
    end
  end

  // one long hold-off so the pipeline and skid buffer fill and stall_o rises
  always @(posedge clk_i or negedge rst_ni) begin : backpressure
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HoldAfter) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    cpf_res_t want;
    if (!rst_ni) begin
      stall_i  <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (valid_o && !stall_i) begin
        if (predicted_checks.size() == 0) begin
          flag_mismatch("unexpected result, is_valid", 4'd0, 4'(is_valid_o));
        end else begin
          want = predicted_checks.pop_front();
          if (is_valid_o !== want.is_valid) begin
            flag_mismatch("is_valid", 4'(want.is_valid), 4'(is_valid_o));
          end
          if (expected_first_check_o !== want.c1) begin
            flag_mismatch("expected_first_check", want.c1, expected_first_check_o);
          end
          if (expected_second_check_o !== want.c2) begin
            flag_mismatch("expected_second_check", want.c2, expected_second_check_o);
          end
          if (rejected_pattern_o !== want.rej) begin
            flag_mismatch("rejected_pattern", 4'(want.rej), 4'(rejected_pattern_o));
          end
        end
        results_seen <= results_seen + 1;
      end
      if (recv_gap != 0) begin
        stall_i  <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if (ids_to_send.size() > TailItems && $urandom_range(0, 9) == 0) begin
        stall_i  <= 1'b1;
        recv_gap <= $urandom_range(0, 16);
      end else begin
        stall_i <= hold_left != 0;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
